// ===== src/rnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rnt_pkg;

  localparam int MAX_HOSTS  = 32;
  localparam int COORD_BITS = 16;

  localparam int SLOT_W     = $clog2(MAX_HOSTS);
  localparam int HOST_IDX_W = 5;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = 33;
  localparam int MASK_W     = 32;
  localparam int CNT_W      = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_QUERY    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ALREADY = 2'd1,
    STAT_NOREG   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic issue;
    logic commit;
    logic out_load;
  } rnt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_walk;
    logic walk_last;
    logic pipe_busy;
  } rnt_stat_t;

endpackage

`default_nettype wire

// ===== src/rnt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire rnt_pkg::rnt_stat_t st,
  output rnt_pkg::rnt_cmd_t      cmd
);
  import rnt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = st.go_walk ? ST_WALK : ST_DONE;
      ST_WALK:  if (st.walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!st.pipe_busy) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_WALK:  cmd.issue = 1'b1;
      ST_DRAIN: cmd.commit = !st.pipe_busy;
      ST_DONE:  cmd.out_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/rnt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rnt_pkg::DIST_W-1:0]          cfg_wr_data,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic [rnt_pkg::HOST_IDX_W-1:0]      in_idx,
  input  wire logic [rnt_pkg::COORD_BITS-1:0]      in_x,
  input  wire logic [rnt_pkg::COORD_BITS-1:0]      in_y,
  input  wire rnt_pkg::rnt_cmd_t                   cmd,
  output rnt_pkg::rnt_stat_t                       st,
  output logic [1:0]                               out_status,
  output logic [rnt_pkg::MASK_W-1:0]               out_mask,
  output logic [rnt_pkg::CNT_W-1:0]                out_added,
  output logic [rnt_pkg::CNT_W-1:0]                out_removed
);
  import rnt_pkg::*;

  // configuration and item registers
  logic [DIST_W-1:0]     max_dist_sq_r;
  logic [1:0]            cmd_r;
  logic [HOST_IDX_W-1:0] idx_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  // table state
  logic [MAX_HOSTS-1:0]  valid_r;
  logic [MAX_HOSTS-1:0]  rows_r [MAX_HOSTS];
  logic [COORD_BITS-1:0] pos_x_mem [MAX_HOSTS];
  logic [COORD_BITS-1:0] pos_y_mem [MAX_HOSTS];

  // working row of the host being handled, and step results
  logic [MAX_HOSTS-1:0]  work_r;
  logic [1:0]            status_r;
  logic [CNT_W-1:0]      added_r, removed_r;

  // walk pipeline
  logic [SLOT_W-1:0]     j_r;
  logic                  s1_v_r, s2_v_r;
  logic [SLOT_W-1:0]     s1_j_r, s2_j_r;
  logic [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [SQ_W-1:0]       sq_x_r, sq_y_r;

  // output register
  logic [1:0]            out_status_r;
  logic [MASK_W-1:0]     out_mask_r;
  logic [CNT_W-1:0]      out_added_r, out_removed_r;

  logic [SLOT_W-1:0]     slot;
  logic                  in_table, slot_ok;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       sq_x, sq_y;
  logic [DIST_W-1:0]     dist_sq;
  logic                  near, upd, linked;
  logic                  write_pos;

  assign slot     = idx_r[SLOT_W-1:0];
  assign in_table = (32'(idx_r) < 32'(MAX_HOSTS));
  assign slot_ok  = in_table && valid_r[slot];

  assign st.go_walk   = (cmd_r == CMD_MOVE) && slot_ok;
  assign st.walk_last = (j_r == SLOT_W'(MAX_HOSTS - 1));
  assign st.pipe_busy = s1_v_r || s2_v_r;

  assign write_pos = cmd.exec && slot_ok == (cmd_r == CMD_MOVE) && in_table
                     && ((cmd_r == CMD_MOVE) || (cmd_r == CMD_REGISTER));

  // stage 1: absolute differences and squares
  assign dx   = (px_r > rd_x_r) ? px_r - rd_x_r : rd_x_r - px_r;
  assign dy   = (py_r > rd_y_r) ? py_r - rd_y_r : rd_y_r - py_r;
  assign sq_x = SQ_W'(dx) * SQ_W'(dx);
  assign sq_y = SQ_W'(dy) * SQ_W'(dy);

  // stage 2: sum, threshold and link update
  assign dist_sq = DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
  assign near    = (dist_sq < max_dist_sq_r);
  assign linked  = work_r[s2_j_r];
  assign upd     = s2_v_r && (s2_j_r != slot) && valid_r[s2_j_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_sq_r <= '0;
      valid_r       <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_dist_sq_r <= cfg_wr_data;
      end
      if (cmd.exec && cmd_r == CMD_REGISTER && in_table && !valid_r[slot]) begin
        valid_r[slot] <= 1'b1;
      end
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  // position store: one write port at the host, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (write_pos) begin
      pos_x_mem[slot] <= px_r;
      pos_y_mem[slot] <= py_r;
    end
    rd_x_r <= pos_x_mem[j_r];
    rd_y_r <= pos_y_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      idx_r <= in_idx;
      px_r  <= in_x;
      py_r  <= in_y;
    end

    if (cmd.exec) begin
      j_r       <= '0;
      added_r   <= '0;
      removed_r <= '0;
      work_r    <= '0;
      status_r  <= STAT_OK;
      case (cmd_r)
        CMD_REGISTER: begin
          if (!in_table) begin
            status_r <= STAT_NOREG;
          end else if (valid_r[slot]) begin
            status_r <= STAT_ALREADY;
          end else begin
            rows_r[slot] <= '0;
          end
        end
        CMD_MOVE, CMD_QUERY: begin
          if (!slot_ok) begin
            status_r <= STAT_NOREG;
          end else begin
            work_r <= rows_r[slot];
          end
        end
        default: status_r <= STAT_OK;
      endcase
    end

    if (cmd.issue) begin
      j_r <= j_r + 1'b1;
    end
    s1_j_r <= j_r;
    s2_j_r <= s1_j_r;
    sq_x_r <= sq_x;
    sq_y_r <= sq_y;

    if (upd) begin
      work_r[s2_j_r]       <= near;
      rows_r[s2_j_r][slot] <= near;
      if (near && !linked && added_r != '1) begin
        added_r <= added_r + 1'b1;
      end
      if (!near && linked && removed_r != '1) begin
        removed_r <= removed_r + 1'b1;
      end
    end

    if (cmd.commit) begin
      rows_r[slot] <= work_r;
    end

    if (cmd.out_load) begin
      out_status_r  <= status_r;
      out_mask_r    <= MASK_W'(work_r);
      out_added_r   <= added_r;
      out_removed_r <= removed_r;
    end
  end

  assign out_status  = out_status_r;
  assign out_mask    = out_mask_r;
  assign out_added   = out_added_r;
  assign out_removed = out_removed_r;

endmodule

`default_nettype wire

// ===== src/radio_neighbor_table_update_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Neighbor table for up to 32 radio hosts: register a slot at a position, move it
// (which relinks it against every other registered slot by squared distance
// strictly below max_dist_sq), or query its neighbor mask. One item is handled at
// a time with one result each. Register, query and unknown commands, and a move of
// an unregistered slot, go from the execute step to the result; a registered move
// walks all slots through a single distance unit (position store read, square stage,
// add and compare stage). The next item is taken while a result waits.
module radio_neighbor_table_update_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rnt_pkg::DIST_W-1:0]      cfg_wr_data,   // max_dist_sq
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rnt_pkg::IN_DATA_W-1:0]   in_tdata,      // host_index, pos_x, pos_y
  input  wire logic [1:0]                      in_tuser,      // cmd
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rnt_pkg::OUT_DATA_W-1:0]       out_tdata,     // neighbor_mask, links_added,
                                                              // links_removed
  output logic [1:0]                           out_tuser      // status
);
  import rnt_pkg::*;

  rnt_cmd_t               cmd;
  rnt_stat_t              st;
  logic [MASK_W-1:0]      mask;
  logic [CNT_W-1:0]       added, removed;

  rnt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  rnt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (in_tuser),
    .in_idx      (in_tdata[HOST_IDX_W-1:0]),
    .in_x        (in_tdata[HOST_IDX_W +: COORD_BITS]),
    .in_y        (in_tdata[HOST_IDX_W + COORD_BITS +: COORD_BITS]),
    .cmd         (cmd),
    .st          (st),
    .out_status  (out_tuser),
    .out_mask    (mask),
    .out_added   (added),
    .out_removed (removed)
  );

  assign out_tdata = OUT_DATA_W'({removed, added, mask});

endmodule

`default_nettype wire

// ===== src/rnt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rnt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [1:0]                      out_tuser
);
  import rnt_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a failed step carries no mask and no counts
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tdata == '0)
    else $error("nonzero payload on failed step");

  // one item at a time: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind radio_neighbor_table_update_unit rnt_checker u_rnt_checker (.*);

`default_nettype wire
